/* hdl/gf2_poly_divsteps_word_top_macros.svh */
// ----------------------------------------------------------------------------
// gf2_poly_divsteps_word_top_macros.svh
// Assertion macros shared by the divstep block.
// ----------------------------------------------------------------------------
`ifndef GF2_POLY_DIVSTEPS_WORD_TOP_MACROS_SVH
`define GF2_POLY_DIVSTEPS_WORD_TOP_MACROS_SVH

// Check a property on the rising clock, muted while reset is held.
`define GPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check that one condition implies another in the same cycle.
`define GPD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that one condition implies another in the next cycle.
`define GPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/gpd_pkg.sv */
// ----------------------------------------------------------------------------
// gpd_pkg
// Types and constants for the binary-polynomial divstep block.
// ----------------------------------------------------------------------------
`default_nettype none

package gpd_pkg;

    // Field widths of the request and result
    localparam int GPD_STEPS_W  = 6;
    localparam int GPD_DELTA_W  = 32;
    localparam int GPD_FIELD_W  = 64;

    // Default number of bit cells in the chain
    localparam int GPD_WORD_BITS = 64;

    // Request payload
    typedef struct packed {
        logic [GPD_STEPS_W-1:0]        steps;
        logic signed [GPD_DELTA_W-1:0] delta_in;
        logic [GPD_FIELD_W-1:0]        f_word;
        logic [GPD_FIELD_W-1:0]        g_word;
    } t_gpd_in;

    // Result payload
    typedef struct packed {
        logic signed [GPD_DELTA_W-1:0] delta_out;
        logic [GPD_FIELD_W-1:0]        mat_u;
        logic [GPD_FIELD_W-1:0]        mat_v;
        logic [GPD_FIELD_W-1:0]        mat_q;
        logic [GPD_FIELD_W-1:0]        mat_r;
    } t_gpd_out;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic load;   // take a new request into the chain
        logic step;   // run one divstep
        logic swap;   // exchange f/g, u/q, v/r this step
        logic fm;     // low bit of f after the swap
        logic gm;     // low bit of g after the swap
    } t_gpd_ctl;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_gpd_state;

endpackage

`default_nettype wire

/* hdl/gpd_cell.sv */
// ----------------------------------------------------------------------------
// gpd_cell
// One bit position of f, g, u, v, q and r. Applies the broadcast swap and
// mask-combine, and takes the shifted g, q and r bits from its upper neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module gpd_cell
    import gpd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_gpd_ctl i_ctl,
    input  wire logic     i_ld_f,
    input  wire logic     i_ld_g,
    input  wire logic     i_ld_start,
    input  wire logic     i_nbr_q,
    input  wire logic     i_nbr_r,
    input  wire logic     i_nbr_g,
    output logic          o_cmb_q,
    output logic          o_cmb_r,
    output logic          o_cmb_g,
    output logic          o_f,
    output logic          o_g,
    output logic          o_u,
    output logic          o_v,
    output logic          o_q,
    output logic          o_r
);

    logic r_f, r_g, r_u, r_v, r_q, r_r;
    logic n_f, n_g, n_u, n_v, n_q, n_r;
    logic w_sf, w_sg, w_su, w_sv, w_sq, w_sr;

    // Swap the pairs when the controller asks
    always_comb begin
        w_sf = i_ctl.swap ? r_g : r_f;
        w_sg = i_ctl.swap ? r_f : r_g;
        w_su = i_ctl.swap ? r_q : r_u;
        w_sv = i_ctl.swap ? r_r : r_v;
        w_sq = i_ctl.swap ? r_u : r_q;
        w_sr = i_ctl.swap ? r_v : r_r;
    end

    // Mask-combine; the result moves one cell down
    assign o_cmb_q = (i_ctl.fm & w_sq) ^ (i_ctl.gm & w_su);
    assign o_cmb_r = (i_ctl.fm & w_sr) ^ (i_ctl.gm & w_sv);
    assign o_cmb_g = (i_ctl.fm & w_sg) ^ (i_ctl.gm & w_sf);

    // Select load, step or hold
    always_comb begin
        n_f = r_f;
        n_g = r_g;
        n_u = r_u;
        n_v = r_v;
        n_q = r_q;
        n_r = r_r;
        if (i_ctl.load) begin
            n_f = i_ld_f;
            n_g = i_ld_g;
            n_u = i_ld_start;
            n_v = 1'b0;
            n_q = 1'b0;
            n_r = i_ld_start;
        end else if (i_ctl.step) begin
            n_f = w_sf;
            n_u = w_su;
            n_v = w_sv;
            n_g = i_nbr_g;
            n_q = i_nbr_q;
            n_r = i_nbr_r;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f <= n_f;
        r_g <= n_g;
        r_u <= n_u;
        r_v <= n_v;
        r_q <= n_q;
        r_r <= n_r;
    end

    assign o_f = r_f;
    assign o_g = r_g;
    assign o_u = r_u;
    assign o_v = r_v;
    assign o_q = r_q;
    assign o_r = r_r;

endmodule

`default_nettype wire

/* hdl/gpd_ctrl.sv */
// ----------------------------------------------------------------------------
// gpd_ctrl
// Step sequencer: holds delta and the remaining step count, decides the
// swap and masks from the low bits of f and g, and hands finished results on.
// ----------------------------------------------------------------------------
`default_nettype none

module gpd_ctrl
    import gpd_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic [GPD_STEPS_W-1:0]        i_steps,
    input  wire logic signed [GPD_DELTA_W-1:0] i_delta,
    input  wire logic                          i_f0,
    input  wire logic                          i_g0,
    input  wire logic                          i_out_free,
    output t_gpd_ctl                           o_ctl,
    output logic                               o_ready,
    output logic                               o_done,
    output logic signed [GPD_DELTA_W-1:0]      o_delta
);

    t_gpd_state                   r_state, n_state;
    logic [GPD_STEPS_W-1:0]       r_count, n_count;
    logic signed [GPD_DELTA_W-1:0] r_delta, n_delta;
    logic                         w_last;
    logic                         w_pos;

    assign w_last = (r_count == '0);
    assign w_pos  = (r_delta != '0) && !r_delta[GPD_DELTA_W-1];

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_last && i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs and cell controls
    always_comb begin
        o_ready    = 1'b0;
        o_done     = 1'b0;
        o_ctl      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready    = 1'b1;
                o_ctl.load = i_valid;
            end
            ST_RUN: begin
                o_ctl.step = !w_last;
                o_done     = w_last && i_out_free;
            end
            default: ;
        endcase
        o_ctl.swap = o_ctl.step && w_pos && i_g0;
        o_ctl.fm   = o_ctl.swap | i_f0;
        o_ctl.gm   = o_ctl.swap ? i_f0 : i_g0;
    end

    // Count down the steps and advance delta
    always_comb begin
        n_count = r_count;
        n_delta = r_delta;
        if (o_ctl.load) begin
            n_count = i_steps;
            n_delta = i_delta;
        end else if (o_ctl.step) begin
            n_count = r_count - GPD_STEPS_W'(1);
            n_delta = (o_ctl.swap ? -r_delta : r_delta) + GPD_DELTA_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_count <= n_count;
        r_delta <= n_delta;
    end

    assign o_delta = r_delta;

endmodule

`default_nettype wire

/* hdl/gf2_poly_divsteps_word_top.sv */
// ----------------------------------------------------------------------------
// gf2_poly_divsteps_word_top
// Word-level GF(2) polynomial divsteps with the 2x2 transition matrix.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (i_valid / o_ready / i_data) carries a step count, the
//   starting delta and the low words of f and g. Result channel
//   (o_valid / i_ready / o_data) returns the final delta and the matrix
//   words u, v, q and r, one result per request.
//   A request is loaded into a row of WORD_BITS bit cells in the cycle it
//   is taken; the chain then runs one divstep per cycle, every cell shifting
//   its g, q and r bits down to its neighbor. When the step count runs out,
//   the result moves into the output register and o_valid rises. The next
//   request is taken only after the previous run has handed its result to
//   the output register; the sequencer accepts no request while it runs.
//   The output register lets a new request start while a result waits.
//   If the receiver stalls and the output register is still full when a
//   run ends, the chain holds its result until the register frees.
//   Reset (synchronous, active low) returns the sequencer to idle and drops
//   o_valid; the data registers are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gf2_poly_divsteps_word_top_macros.svh"

module gf2_poly_divsteps_word_top
    import gpd_pkg::*;
#(
    parameter int WORD_BITS = GPD_WORD_BITS
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_gpd_in i_data,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_gpd_out     o_data
);

    t_gpd_ctl                      w_ctl;
    logic                          w_done;
    logic                          w_out_free;
    logic                          w_in_acc;
    logic signed [GPD_DELTA_W-1:0] w_delta;
    logic [WORD_BITS-1:0]          w_start;
    logic [WORD_BITS-1:0]          w_f, w_g, w_u, w_v, w_q, w_r;
    logic [WORD_BITS-1:0]          w_cmb_q, w_cmb_r, w_cmb_g;
    logic [WORD_BITS-1:0]          w_nbr_q, w_nbr_r, w_nbr_g;
    logic                          r_out_valid;
    t_gpd_out                      r_out;

    assign w_in_acc   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;

    // Decode the starting power of x; it drops off when steps >= WORD_BITS
    assign w_start = WORD_BITS'(1) << i_data.steps;

    // Sequencer
    gpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_steps    (i_data.steps),
        .i_delta    (i_data.delta_in),
        .i_f0       (w_f[0]),
        .i_g0       (w_g[0]),
        .i_out_free (w_out_free),
        .o_ctl      (w_ctl),
        .o_ready    (o_ready),
        .o_done     (w_done),
        .o_delta    (w_delta)
    );

    // Shift path: each cell takes the combined bits of the cell above it
    assign w_nbr_q = {1'b0, w_cmb_q[WORD_BITS-1:1]};
    assign w_nbr_r = {1'b0, w_cmb_r[WORD_BITS-1:1]};
    assign w_nbr_g = {1'b0, w_cmb_g[WORD_BITS-1:1]};

    // Row of bit cells
    for (genvar k = 0; k < WORD_BITS; k++) begin : g_cell
        gpd_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_ld_f     (i_data.f_word[k]),
            .i_ld_g     (i_data.g_word[k]),
            .i_ld_start (w_start[k]),
            .i_nbr_q    (w_nbr_q[k]),
            .i_nbr_r    (w_nbr_r[k]),
            .i_nbr_g    (w_nbr_g[k]),
            .o_cmb_q    (w_cmb_q[k]),
            .o_cmb_r    (w_cmb_r[k]),
            .o_cmb_g    (w_cmb_g[k]),
            .o_f        (w_f[k]),
            .o_g        (w_g[k]),
            .o_u        (w_u[k]),
            .o_v        (w_v[k]),
            .o_q        (w_q[k]),
            .o_r        (w_r[k])
        );
    end

    // Output register: load on completion, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out.delta_out <= w_delta;
            r_out.mat_u     <= GPD_FIELD_W'(w_u);
            r_out.mat_v     <= GPD_FIELD_W'(w_v);
            r_out.mat_q     <= GPD_FIELD_W'(w_q);
            r_out.mat_r     <= GPD_FIELD_W'(w_r);
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // Checks
    `GPD_ASSERT_NEXT(a_busy_after_req, w_in_acc, !o_ready, "request taken while still busy")
    `GPD_ASSERT_IMPL(a_done_needs_room, w_done, w_out_free, "result overwrote a waiting result")
    `GPD_ASSERT_NEXT(a_done_shows_valid, w_done, o_valid, "finished result not presented")
    `GPD_ASSERT(a_no_load_while_busy, !(w_ctl.load && (w_ctl.step || w_done)), "load overlaps run")

endmodule

`default_nettype wire
